FILE: hdl/i2cms_pkg.sv
package i2cms_pkg;

    localparam int unsigned MAX_LENGTH = 255;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_BYTE   = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    localparam logic [2:0] K_ADDR = 3'd0;
    localparam logic [2:0] K_DATA = 3'd1;
    localparam logic [2:0] K_CTRL = 3'd2;
    localparam logic [2:0] K_RX   = 3'd3;
    localparam logic [2:0] K_NEED = 3'd4;
    localparam logic [2:0] K_DONE = 3'd5;

    localparam logic [7:0] CW_ACK   = 8'h08;
    localparam logic [7:0] CW_STOP  = 8'h04;
    localparam logic [7:0] CW_START = 8'h02;
    localparam logic [7:0] CW_RUN   = 8'h01;

    localparam int unsigned ST_DATA_NACK = 3;
    localparam int unsigned ST_ADDR_NACK = 2;
    localparam int unsigned ST_ERROR     = 1;
    localparam int unsigned ST_BUSY      = 0;

    localparam logic [3:0] RETRIES_RST = 4'd3;
    localparam logic [7:0] RX_BAD      = 8'hFF;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       failed;
    } result_t;

endpackage

FILE: hdl/i2c_master_transfer_sequencer_core.sv
// Channel  Direction  Handshake              Payload
// in       receive    in_valid / in_stall    cmd, is_read, slave_addr, xfer_length,
//                                            repeat_start, data_byte, engine_status,
//                                            engine_rx_byte
// out      send       out_valid / out_stall  kind, value, failed, last
// cfg      receive    cfg_wr_en              cfg_wr_data (max_retries)
//
// An item is registered, then decoded combinationally into a result buffer of up to three results.
// Results leave one per cycle while out_stall is low; an item waits until the last result of the one before leaves.
// Items giving no result pass at one per cycle; a first result follows the input register, then the result buffer.
// rst_n clears control state and sets max_retries to 3; no clearing pass.
// out_stall holds the result buffer; in_stall rises only when the input register cannot move on.
module i2c_master_transfer_sequencer_core
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic       is_read,
    input  logic [6:0] slave_addr,
    input  logic [7:0] xfer_length,
    input  logic       repeat_start,
    input  logic [7:0] data_byte,
    input  logic [3:0] engine_status,
    input  logic [7:0] engine_rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] value,
    output logic       failed,
    output logic       last
);

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_WAIT_STATUS = 2'd1,
        PH_WAIT_HOST   = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       reading_reg, reading_next;
    logic [6:0] target_reg, target_next;
    logic [7:0] total_reg, total_next;
    logic [7:0] index_reg, index_next;
    logic [3:0] attempt_reg, attempt_next;
    logic       hold_reg, hold_next;
    logic [3:0] max_retries_reg;

    logic       in_full_reg;
    logic [1:0] cmd_reg;
    logic       is_read_reg;
    logic [6:0] slave_addr_reg;
    logic [7:0] xfer_length_reg;
    logic       repeat_start_reg;
    logic [7:0] data_byte_reg;
    logic [3:0] status_reg;
    logic [7:0] rx_byte_reg;

    result_t    res_reg [3];
    logic [1:0] res_cnt_reg;
    logic [1:0] res_idx_reg;

    result_t    res_calc [3];
    logic [1:0] n_calc;
    logic [7:0] index_inc;
    logic       res_last;
    logic       out_fire;
    logic       buf_free;
    logic       adv;
    logic       in_fire;

    function automatic logic [7:0] read_ctl(input logic [7:0] total, input logic [7:0] idx);
        logic [7:0] cw;
        if (total == 8'd1)
            cw = CW_STOP | CW_START | CW_RUN;
        else if (idx == 8'd0)
            cw = CW_ACK | CW_START | CW_RUN;
        else if (({1'b0, idx} + 9'd1) == {1'b0, total})
            cw = CW_STOP | CW_RUN;
        else
            cw = CW_ACK | CW_RUN;
        return cw;
    endfunction

    function automatic logic [7:0] write_ctl(input logic [7:0] total, input logic [7:0] idx,
                                             input logic hold);
        logic [7:0] cw;
        if (total == 8'd1)
            cw = CW_START | CW_RUN | (hold ? 8'h00 : CW_STOP);
        else if (idx == 8'd0)
            cw = CW_START | CW_RUN;
        else if (({1'b0, idx} + 9'd1) == {1'b0, total})
            cw = CW_STOP | CW_RUN;
        else
            cw = CW_RUN;
        return cw;
    endfunction

    assign out_valid = (res_cnt_reg != 2'd0);
    assign res_last  = (res_idx_reg == (res_cnt_reg - 2'd1));
    assign out_fire  = out_valid && !out_stall;
    assign buf_free  = !out_valid || (out_fire && res_last);
    assign adv       = in_full_reg && buf_free;
    assign in_stall  = in_full_reg && !buf_free;
    assign in_fire   = in_valid && !in_stall;

    assign kind   = res_reg[res_idx_reg].kind;
    assign value  = res_reg[res_idx_reg].value;
    assign failed = res_reg[res_idx_reg].failed;
    assign last   = res_last;

    assign index_inc = index_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        reading_next = reading_reg;
        target_next  = target_reg;
        total_next   = total_reg;
        index_next   = index_reg;
        attempt_next = attempt_reg;
        hold_next    = hold_reg;
        n_calc       = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res_calc[i] = '0;
        end

        unique case (cmd_reg)
            CMD_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (xfer_length_reg == 8'd0 || 32'(xfer_length_reg) > MAX_LENGTH)
                    begin
                        res_calc[n_calc] = '{K_DONE, 8'd0, 1'b1};
                        n_calc = n_calc + 2'd1;
                    end
                    else
                    begin
                        reading_next = is_read_reg;
                        target_next  = slave_addr_reg;
                        total_next   = xfer_length_reg;
                        hold_next    = repeat_start_reg;
                        index_next   = 8'd0;
                        attempt_next = 4'd0;
                        if (slave_addr_reg != 7'd0)
                        begin
                            res_calc[n_calc] = '{K_ADDR, {slave_addr_reg, is_read_reg}, 1'b0};
                            n_calc = n_calc + 2'd1;
                        end
                        if (is_read_reg)
                        begin
                            res_calc[n_calc] = '{K_CTRL, read_ctl(xfer_length_reg, 8'd0), 1'b0};
                            n_calc = n_calc + 2'd1;
                        end
                        else
                        begin
                            res_calc[n_calc] = '{K_DATA, data_byte_reg, 1'b0};
                            n_calc = n_calc + 2'd1;
                            res_calc[n_calc] = '{K_CTRL,
                                write_ctl(xfer_length_reg, 8'd0, repeat_start_reg), 1'b0};
                            n_calc = n_calc + 2'd1;
                        end
                        phase_next = PH_WAIT_STATUS;
                    end
                end
            end
            CMD_BYTE:
            begin
                if (phase_reg == PH_WAIT_HOST)
                begin
                    res_calc[n_calc] = '{K_DATA, data_byte_reg, 1'b0};
                    n_calc = n_calc + 2'd1;
                    res_calc[n_calc] = '{K_CTRL, write_ctl(total_reg, index_reg, hold_reg), 1'b0};
                    n_calc = n_calc + 2'd1;
                    phase_next = PH_WAIT_STATUS;
                end
            end
            CMD_STATUS:
            begin
                if (phase_reg == PH_WAIT_STATUS && !status_reg[ST_BUSY])
                begin
                    if (reading_reg)
                    begin
                        if ((status_reg[ST_ADDR_NACK] || status_reg[ST_ERROR])
                            && attempt_reg < max_retries_reg)
                        begin
                            attempt_next = attempt_reg + 4'd1;
                            if (index_reg == 8'd0 && target_reg != 7'd0)
                            begin
                                res_calc[n_calc] = '{K_ADDR, {target_reg, 1'b1}, 1'b0};
                                n_calc = n_calc + 2'd1;
                            end
                            res_calc[n_calc] = '{K_CTRL, read_ctl(total_reg, index_reg), 1'b0};
                            n_calc = n_calc + 2'd1;
                        end
                        else if (rx_byte_reg == RX_BAD)
                        begin
                            res_calc[n_calc] = '{K_DONE, 8'd0, 1'b1};
                            n_calc = n_calc + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            res_calc[n_calc] = '{K_RX, rx_byte_reg, 1'b0};
                            n_calc = n_calc + 2'd1;
                            index_next   = index_inc;
                            attempt_next = 4'd0;
                            if (index_inc >= total_reg)
                            begin
                                res_calc[n_calc] = '{K_DONE, 8'd0, 1'b0};
                                n_calc = n_calc + 2'd1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                // index_inc is never zero here, so no address write
                                res_calc[n_calc] = '{K_CTRL, read_ctl(total_reg, index_inc),
                                                     1'b0};
                                n_calc = n_calc + 2'd1;
                            end
                        end
                    end
                    else
                    begin
                        if (status_reg[ST_DATA_NACK] || status_reg[ST_ADDR_NACK]
                            || status_reg[ST_ERROR])
                        begin
                            res_calc[n_calc] = '{K_CTRL, CW_STOP, 1'b0};
                            n_calc = n_calc + 2'd1;
                            res_calc[n_calc] = '{K_DONE, 8'd0, 1'b1};
                            n_calc = n_calc + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            index_next = index_inc;
                            if (index_inc >= total_reg)
                            begin
                                res_calc[n_calc] = '{K_DONE, 8'd0, 1'b0};
                                n_calc = n_calc + 2'd1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                res_calc[n_calc] = '{K_NEED, index_inc, 1'b0};
                                n_calc = n_calc + 2'd1;
                                phase_next = PH_WAIT_HOST;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            reading_reg     <= 1'b0;
            target_reg      <= 7'd0;
            total_reg       <= 8'd0;
            index_reg       <= 8'd0;
            attempt_reg     <= 4'd0;
            hold_reg        <= 1'b0;
            max_retries_reg <= RETRIES_RST;
            in_full_reg     <= 1'b0;
            res_cnt_reg     <= 2'd0;
            res_idx_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_retries_reg <= cfg_wr_data;
            end
            if (adv)
            begin
                phase_reg   <= phase_next;
                reading_reg <= reading_next;
                target_reg  <= target_next;
                total_reg   <= total_next;
                index_reg   <= index_next;
                attempt_reg <= attempt_next;
                hold_reg    <= hold_next;
                res_cnt_reg <= n_calc;
                res_idx_reg <= 2'd0;
            end
            else if (out_fire)
            begin
                if (res_last)
                begin
                    res_cnt_reg <= 2'd0;
                    res_idx_reg <= 2'd0;
                end
                else
                begin
                    res_idx_reg <= res_idx_reg + 2'd1;
                end
            end
            if (in_fire)
            begin
                in_full_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg          <= cmd;
            is_read_reg      <= is_read;
            slave_addr_reg   <= slave_addr;
            xfer_length_reg  <= xfer_length;
            repeat_start_reg <= repeat_start;
            data_byte_reg    <= data_byte;
            status_reg       <= engine_status;
            rx_byte_reg      <= engine_rx_byte;
        end
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_calc[i];
            end
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (res_idx_reg < res_cnt_reg))
        else $error("result index beyond buffer count");

    a_index_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (total_reg != 8'd0 && index_reg < total_reg))
        else $error("byte index out of transfer range");

    a_failed_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != K_DONE) |-> !failed)
        else $error("failed set on a non-done result");

    a_attempts_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE && !reading_reg) |-> (attempt_reg == 4'd0))
        else $error("retry count set on a write transfer");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == K_DONE) |-> last)
        else $error("done result not last of its item");

endmodule
